### hdl/uf_pkg.sv
// ----------------------------------------------------------------------------
// uf_pkg
// Types, constants and helpers shared by the union-find engine.
// ----------------------------------------------------------------------------
package uf_pkg;

    localparam int ELEMENTS = 1024;
    localparam int IDX_W    = $clog2(ELEMENTS);
    localparam int CNT_W    = $clog2(ELEMENTS + 1);

    localparam logic [1:0] REQ_UNION = 2'd0;
    localparam logic [1:0] REQ_FIND  = 2'd1;
    localparam logic [1:0] REQ_SIZE  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [9:0] elem_a;
        logic [9:0] elem_b;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  root_index;
        logic [10:0] set_size;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_par_req;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_cnt_req;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WALK,
        ST_COMP,
        ST_RD_SIZE,
        ST_SIZE,
        ST_LINK,
        ST_CNT_Q,
        ST_SUM,
        ST_OUT
    } t_state;

    function automatic logic [IDX_W-1:0] clamp_elem(input logic [9:0] v);
        if (32'(v) >= ELEMENTS) begin
            return IDX_W'(ELEMENTS - 1);
        end
        return IDX_W'(v);
    endfunction

endpackage

### hdl/uf_ram.sv
// ----------------------------------------------------------------------------
// uf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module uf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/uf_ctrl.sv
// ----------------------------------------------------------------------------
// uf_ctrl
// Request sequencer: clearing sweep, root walk, path compression, linking,
// size update and the output register.
// ----------------------------------------------------------------------------
module uf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  uf_pkg::t_in_item            i_in_item,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output uf_pkg::t_out_item           o_out_item,
    input  logic                        i_out_stall,
    output uf_pkg::t_par_req            o_par_req,
    input  logic [uf_pkg::IDX_W-1:0]    i_par_rdata,
    output uf_pkg::t_cnt_req            o_cnt_req,
    input  logic [uf_pkg::CNT_W-1:0]    i_cnt_rdata
);

    uf_pkg::t_state           r_state, n_state;
    logic                     r_union, n_union;
    logic                     r_second, n_second;
    logic [uf_pkg::IDX_W-1:0] r_a, n_a;
    logic [uf_pkg::IDX_W-1:0] r_b, n_b;
    logic [uf_pkg::IDX_W-1:0] r_cur, n_cur;
    logic [uf_pkg::IDX_W-1:0] r_start, n_start;
    logic [uf_pkg::IDX_W-1:0] r_root, n_root;
    logic [uf_pkg::IDX_W-1:0] r_p, n_p;
    logic [uf_pkg::CNT_W-1:0] r_cp, n_cp;
    logic [uf_pkg::CNT_W-1:0] r_size, n_size;
    logic                     r_out_valid, n_out_valid;
    uf_pkg::t_out_item        r_out_item, n_out_item;

    logic                     found;
    logic [uf_pkg::IDX_W-1:0] root_now;
    logic [uf_pkg::CNT_W-1:0] sum;

    assign sum = r_cp + i_cnt_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= uf_pkg::ST_CLEAR;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
        r_union    <= n_union;
        r_second   <= n_second;
        r_a        <= n_a;
        r_b        <= n_b;
        r_start    <= n_start;
        r_root     <= n_root;
        r_p        <= n_p;
        r_cp       <= n_cp;
        r_size     <= n_size;
        r_out_item <= n_out_item;
    end

    always_comb begin
        n_state     = r_state;
        n_union     = r_union;
        n_second    = r_second;
        n_a         = r_a;
        n_b         = r_b;
        n_cur       = r_cur;
        n_start     = r_start;
        n_root      = r_root;
        n_p         = r_p;
        n_cp        = r_cp;
        n_size      = r_size;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_par_req   = '0;
        o_cnt_req   = '0;
        found       = 1'b0;
        root_now    = r_root;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            uf_pkg::ST_CLEAR: begin
                o_par_req.we    = 1'b1;
                o_par_req.waddr = r_cur;
                o_par_req.wdata = r_cur;
                o_cnt_req.we    = 1'b1;
                o_cnt_req.waddr = r_cur;
                o_cnt_req.wdata = uf_pkg::CNT_W'(1);
                n_cur           = r_cur + 1'b1;
                if (r_cur == uf_pkg::IDX_W'(uf_pkg::ELEMENTS - 1)) begin
                    n_state = uf_pkg::ST_IDLE;
                end
            end
            uf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_union = (i_in_item.req_type == uf_pkg::REQ_UNION);
                    n_a     = uf_pkg::clamp_elem(i_in_item.elem_a);
                    n_b     = uf_pkg::clamp_elem(i_in_item.elem_b);
                    n_state = uf_pkg::ST_RD_A;
                end
            end
            uf_pkg::ST_RD_A: begin
                o_par_req.raddr = r_a;
                n_cur           = r_a;
                n_start         = r_a;
                n_second        = 1'b0;
                n_state         = uf_pkg::ST_WALK;
            end
            uf_pkg::ST_RD_B: begin
                o_par_req.raddr = r_b;
                n_cur           = r_b;
                n_start         = r_b;
                n_second        = 1'b1;
                n_state         = uf_pkg::ST_WALK;
            end
            uf_pkg::ST_WALK: begin
                if (i_par_rdata == r_cur) begin
                    n_root   = r_cur;
                    root_now = r_cur;
                    if (r_start == r_cur) begin
                        found = 1'b1;
                    end else begin
                        o_par_req.raddr = r_start;
                        n_cur           = r_start;
                        n_state         = uf_pkg::ST_COMP;
                    end
                end else begin
                    o_par_req.raddr = i_par_rdata;
                    n_cur           = i_par_rdata;
                end
            end
            uf_pkg::ST_COMP: begin
                // point the visited element at the root
                o_par_req.we    = 1'b1;
                o_par_req.waddr = r_cur;
                o_par_req.wdata = r_root;
                if (i_par_rdata == r_root) begin
                    found = 1'b1;
                end else begin
                    o_par_req.raddr = i_par_rdata;
                    n_cur           = i_par_rdata;
                end
            end
            uf_pkg::ST_RD_SIZE: begin
                o_cnt_req.raddr = r_root;
                n_state         = uf_pkg::ST_SIZE;
            end
            uf_pkg::ST_SIZE: begin
                n_size  = i_cnt_rdata;
                n_state = uf_pkg::ST_OUT;
            end
            uf_pkg::ST_LINK: begin
                o_par_req.we    = 1'b1;
                o_par_req.waddr = r_p;
                o_par_req.wdata = r_root;
                o_cnt_req.raddr = r_p;
                n_state         = uf_pkg::ST_CNT_Q;
            end
            uf_pkg::ST_CNT_Q: begin
                n_cp            = i_cnt_rdata;
                o_cnt_req.raddr = r_root;
                n_state         = uf_pkg::ST_SUM;
            end
            uf_pkg::ST_SUM: begin
                o_cnt_req.we    = 1'b1;
                o_cnt_req.waddr = r_root;
                o_cnt_req.wdata = sum;
                n_size          = sum;
                n_state         = uf_pkg::ST_OUT;
            end
            uf_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out_item.root_index = 10'(r_root);
                    n_out_item.set_size   = 11'(r_size);
                    n_state               = uf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = uf_pkg::ST_IDLE;
            end
        endcase

        // root of the current walk is known
        if (found) begin
            if (r_union && !r_second) begin
                n_p     = root_now;
                n_state = uf_pkg::ST_RD_B;
            end else if (r_union && (r_p != root_now)) begin
                n_state = uf_pkg::ST_LINK;
            end else begin
                n_state = uf_pkg::ST_RD_SIZE;
            end
        end
    end

    assign o_in_stall  = (r_state != uf_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### hdl/union_find_with_set_sizes.sv
// ----------------------------------------------------------------------------
// union_find_with_set_sizes
// Disjoint-set engine with path compression and per-root set sizes.
// ----------------------------------------------------------------------------
//  channel  | signals                              | moves
//  ---------+--------------------------------------+---------------------------
//  request  | i_in_valid, i_in_item, o_in_stall    | req_type, elem_a, elem_b
//  result   | o_out_valid, o_out_item, i_out_stall | root_index, set_size
//
//  a find or size transaction walks one path; a union walks both paths and
//  links the two sets when their roots differ;
//  the parent memory's single read port sets one step per cycle on each pass
//  after reset a sweep fills both memories while requests stall;
//  one transaction is in work at a time; a finished result waits in the
//  output register while the next request is taken
// ----------------------------------------------------------------------------
module union_find_with_set_sizes (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  uf_pkg::t_in_item  i_in_item,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output uf_pkg::t_out_item o_out_item,
    input  logic              i_out_stall
);

    uf_pkg::t_par_req         par_req;
    uf_pkg::t_cnt_req         cnt_req;
    logic [uf_pkg::IDX_W-1:0] par_rdata;
    logic [uf_pkg::CNT_W-1:0] cnt_rdata;

    uf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .o_par_req   (par_req),
        .i_par_rdata (par_rdata),
        .o_cnt_req   (cnt_req),
        .i_cnt_rdata (cnt_rdata)
    );

    uf_ram #(
        .WIDTH (uf_pkg::IDX_W),
        .DEPTH (uf_pkg::ELEMENTS)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (par_req.we),
        .i_waddr (par_req.waddr),
        .i_wdata (par_req.wdata),
        .i_raddr (par_req.raddr),
        .o_rdata (par_rdata)
    );

    uf_ram #(
        .WIDTH (uf_pkg::CNT_W),
        .DEPTH (uf_pkg::ELEMENTS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_req.we),
        .i_waddr (cnt_req.waddr),
        .i_wdata (cnt_req.wdata),
        .i_raddr (cnt_req.raddr),
        .o_rdata (cnt_rdata)
    );

endmodule
